// File: src/vfcm_pkg.sv
// Package for the voxel face culling mesher.
// Holds the chunk limits, the face codes, the corner and light tables and the job type.
// No dependencies.
package vfcm_pkg;

  localparam int unsigned CHUNK_WIDTH  = 16;
  localparam int unsigned CHUNK_HEIGHT = 16;
  localparam int unsigned CHUNK_LENGTH = 16;

  localparam int unsigned NUM_FACES      = 6;
  localparam int unsigned VERTS_PER_FACE = 6;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic [2:0] {
    FACE_UP    = 3'd0,
    FACE_DOWN  = 3'd1,
    FACE_EAST  = 3'd2,
    FACE_WEST  = 3'd3,
    FACE_SOUTH = 3'd4,
    FACE_NORTH = 3'd5
  } face_t;

  // corner offsets per vertex: [4] dx, [3] dy, [2] dz, [1] du, [0] dv
  localparam logic [4:0] CORNER_TAB [0:5][0:5] = '{
    '{5'b01010, 5'b01111, 5'b11101, 5'b01010, 5'b11101, 5'b11000},
    '{5'b00000, 5'b10111, 5'b00101, 5'b00000, 5'b10010, 5'b10111},
    '{5'b10010, 5'b11011, 5'b11101, 5'b10010, 5'b11101, 5'b10100},
    '{5'b00000, 5'b01111, 5'b01001, 5'b00000, 5'b00110, 5'b01111},
    '{5'b00100, 5'b11111, 5'b01101, 5'b00100, 5'b10110, 5'b11111},
    '{5'b00010, 5'b01011, 5'b11001, 5'b00010, 5'b11001, 5'b10000}
  };

  localparam logic [6:0] FACE_LIGHT [0:5] = '{
    7'd100, 7'd75, 7'd95, 7'd85, 7'd90, 7'd80
  };

  // one visible voxel, ready for vertex generation
  typedef struct packed {
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] z;
    logic [3:0] base_u;
    logic [3:0] base_v;
    logic [5:0] face_mask;
  } job_t;

  function automatic face_t lowest_face(input logic [5:0] mask);
    face_t f;
    f = FACE_UP;
    for (int i = int'(NUM_FACES) - 1; i >= 0; i--) begin
      if (mask[i]) f = face_t'(3'(i));
    end
    return f;
  endfunction

endpackage

// File: src/vfcm_if.sv
// Handshake channels of the voxel face culling mesher: voxel in, vertex out.
// Depends on nothing; plain valid/ready with the payload fields.
interface vfcm_voxel_if;
  logic       valid;
  logic       ready;
  logic [3:0] vox_x;
  logic [3:0] vox_y;
  logic [3:0] vox_z;
  logic [7:0] block_id;
  logic       open_up;
  logic       open_down;
  logic       open_east;
  logic       open_west;
  logic       open_south;
  logic       open_north;

  modport source (
    output valid, vox_x, vox_y, vox_z, block_id,
    output open_up, open_down, open_east, open_west, open_south, open_north,
    input  ready
  );
  modport sink (
    input  valid, vox_x, vox_y, vox_z, block_id,
    input  open_up, open_down, open_east, open_west, open_south, open_north,
    output ready
  );
endinterface

interface vfcm_vertex_if;
  logic       valid;
  logic       ready;
  logic [4:0] pos_x;
  logic [4:0] pos_y;
  logic [4:0] pos_z;
  logic [4:0] tex_u;
  logic [4:0] tex_v;
  logic [6:0] light_level;
  logic [2:0] face_dir;
  logic       last_vertex;

  modport source (
    output valid, pos_x, pos_y, pos_z, tex_u, tex_v, light_level, face_dir, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, tex_u, tex_v, light_level, face_dir, last_vertex,
    output ready
  );
endinterface

// File: src/vfcm_queue.sv
// Short job queue between the classifier and the vertex generator.
// Depends on vfcm_pkg.
module vfcm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vfcm_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output vfcm_pkg::job_t pop_job
);
  import vfcm_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  job_t              mem [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       count;

  assign full      = (count == (PW+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

// File: src/vfcm_front.sv
// Front end: takes voxels, culls empty, enclosed or out-of-chunk ones and queues visible jobs.
// Depends on vfcm_pkg, vfcm_if and vfcm_queue.
module vfcm_front (
  input  logic           clk,
  input  logic           rst,
  vfcm_voxel_if.sink     voxel,
  input  logic           pop,
  output logic           job_valid,
  output vfcm_pkg::job_t job
);
  import vfcm_pkg::*;

  localparam logic [8:0] LIM_X = 9'(CHUNK_WIDTH);
  localparam logic [8:0] LIM_Y = 9'(CHUNK_HEIGHT);
  localparam logic [8:0] LIM_Z = 9'(CHUNK_LENGTH);

  logic in_chunk;
  logic full;
  logic push;
  job_t new_job;

  assign in_chunk = ({5'd0, voxel.vox_x} < LIM_X) && ({5'd0, voxel.vox_y} < LIM_Y)
                 && ({5'd0, voxel.vox_z} < LIM_Z);

  always_comb begin
    new_job.x      = voxel.vox_x;
    new_job.y      = voxel.vox_y;
    new_job.z      = voxel.vox_z;
    new_job.base_u = voxel.block_id[3:0];
    new_job.base_v = ~voxel.block_id[7:4];  // 15 - id/16
    new_job.face_mask = {voxel.open_north, voxel.open_south, voxel.open_west,
                         voxel.open_east, voxel.open_down, voxel.open_up};
    if (voxel.block_id == 8'd0 || !in_chunk) new_job.face_mask = '0;
  end

  // culled voxels are taken and dropped here
  assign voxel.ready = !full;
  assign push        = voxel.valid && !full && (new_job.face_mask != '0);

  vfcm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (new_job),
    .full      (full),
    .pop       (pop),
    .pop_valid (job_valid),
    .pop_job   (job)
  );
endmodule

// File: src/vfcm_back.sv
// Back end: walks the open faces of one job and emits six vertices per face.
// Depends on vfcm_pkg and vfcm_if.
module vfcm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  vfcm_pkg::job_t job,
  output logic           pop,
  vfcm_vertex_if.source  vertex
);
  import vfcm_pkg::*;

  logic       busy;
  job_t       cur;
  face_t      face;
  logic [2:0] vtx;

  logic       out_valid;
  logic [4:0] pos_x, pos_y, pos_z, tex_u, tex_v;
  logic [6:0] light;
  face_t      out_face;
  logic       last;

  logic       advance;
  logic       face_done;
  logic [5:0] rest_mask;
  logic       final_vtx;
  logic [4:0] corner;

  assign advance   = !out_valid || vertex.ready;
  assign face_done = (vtx == 3'(VERTS_PER_FACE - 1));

  always_comb begin
    for (int i = 0; i < int'(NUM_FACES); i++) begin
      rest_mask[i] = cur.face_mask[i] && (i > int'(face));
    end
  end

  assign final_vtx = face_done && (rest_mask == '0);
  assign corner    = CORNER_TAB[face][vtx];
  assign pop       = job_valid && (!busy || (advance && final_vtx));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      face      <= FACE_UP;
      vtx       <= '0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        face <= lowest_face(job.face_mask);
        vtx  <= '0;
      end else if (busy && advance) begin
        if (final_vtx) begin
          busy <= 1'b0;
        end else if (face_done) begin
          face <= lowest_face(rest_mask);
          vtx  <= '0;
        end else begin
          vtx <= vtx + 1'b1;
        end
      end
      if (advance) out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= job;
    if (busy && advance) begin
      pos_x    <= {1'b0, cur.x} + {4'd0, corner[4]};
      pos_y    <= {1'b0, cur.y} + {4'd0, corner[3]};
      pos_z    <= {1'b0, cur.z} + {4'd0, corner[2]};
      tex_u    <= {1'b0, cur.base_u} + {4'd0, corner[1]};
      tex_v    <= {1'b0, cur.base_v} + {4'd0, corner[0]};
      light    <= FACE_LIGHT[face];
      out_face <= face;
      last     <= final_vtx;
    end
  end

  assign vertex.valid       = out_valid;
  assign vertex.pos_x       = pos_x;
  assign vertex.pos_y       = pos_y;
  assign vertex.pos_z       = pos_z;
  assign vertex.tex_u       = tex_u;
  assign vertex.tex_v       = tex_v;
  assign vertex.light_level = light;
  assign vertex.face_dir    = out_face;
  assign vertex.last_vertex = last;
endmodule

// File: src/voxel_face_culling_mesher.sv
// Voxel face culling mesher. One voxel in, six vertices out for every exposed face,
// faces in the order up, down, east, west, south, north; last_vertex marks the end of a
// voxel. A voxel yields 6 to 36 vertices, emitted by the vertex walker through the
// single output register; empty, enclosed or out-of-chunk voxels emit nothing and are
// taken one per cycle unless the job queue is full. A two-deep job queue lets voxels
// be taken while the previous one is still being emitted, and the next voxel's first
// vertex follows the last one of its predecessor without a gap.
// Depends on vfcm_pkg, vfcm_if, vfcm_front and vfcm_back.
module voxel_face_culling_mesher (
  input  logic          clk,
  input  logic          rst,
  vfcm_voxel_if.sink    voxel,
  vfcm_vertex_if.source vertex
);
  import vfcm_pkg::*;

  logic job_valid;
  logic pop;
  job_t job;

  vfcm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .voxel     (voxel),
    .pop       (pop),
    .job_valid (job_valid),
    .job       (job)
  );

  vfcm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop),
    .vertex    (vertex)
  );
endmodule

// File: tb/tb_voxel_face_culling_mesher.sv
// Self-checking testbench for voxel_face_culling_mesher: voxels in, culled face vertices out.
// Predicts every vertex per accepted voxel and checks each one in order.
// Depends on vfcm_pkg, vfcm_if and the mesher RTL.
module tb_voxel_face_culling_mesher;
  timeunit 1ns;
  timeprecision 1ps;

  import vfcm_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 3000;
  localparam int unsigned DRAIN_TAIL  = 40;
  localparam int unsigned RANDOM_VOXELS = 320;

  // corner offsets per vertex, bits dx dy dz du dv from msb down
  localparam bit [4:0] FACE_CORNERS [6][6] = '{
    '{5'b01010, 5'b01111, 5'b11101, 5'b01010, 5'b11101, 5'b11000},
    '{5'b00000, 5'b10111, 5'b00101, 5'b00000, 5'b10010, 5'b10111},
    '{5'b10010, 5'b11011, 5'b11101, 5'b10010, 5'b11101, 5'b10100},
    '{5'b00000, 5'b01111, 5'b01001, 5'b00000, 5'b00110, 5'b01111},
    '{5'b00100, 5'b11111, 5'b01101, 5'b00100, 5'b10110, 5'b11111},
    '{5'b00010, 5'b01011, 5'b11001, 5'b00010, 5'b11001, 5'b10000}
  };
  localparam bit [6:0] FACE_BRIGHTNESS [6] = '{7'd100, 7'd75, 7'd95, 7'd85, 7'd90, 7'd80};

  typedef struct packed {
    logic [4:0] pos_x;
    logic [4:0] pos_y;
    logic [4:0] pos_z;
    logic [4:0] tex_u;
    logic [4:0] tex_v;
    logic [6:0] light;
    face_t      face;
    logic       last;
  } mesh_vertex_t;

  logic clk;
  logic rst;

  vfcm_voxel_if  voxel ();
  vfcm_vertex_if vertex ();

  voxel_face_culling_mesher dut (
    .clk    (clk),
    .rst    (rst),
    .voxel  (voxel),
    .vertex (vertex)
  );

  mesh_vertex_t pending_vertices [$];
  int unsigned  mismatches;
  int unsigned  idle_cycles;
  bit           tx_steady;
  bit           rx_steady;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // expected vertices for one voxel, appended in emission order
  function automatic void predict_voxel_mesh(input logic [3:0] x, input logic [3:0] y,
                                             input logic [3:0] z, input logic [7:0] id,
                                             input logic [5:0] open_mask);
    mesh_vertex_t vtx;
    bit [4:0]     c;
    logic [3:0]   tile_u;
    logic [3:0]   tile_v;
    int           first;
    first = pending_vertices.size();
    if (id == 8'd0) return;
    if (x >= CHUNK_WIDTH || y >= CHUNK_HEIGHT || z >= CHUNK_LENGTH) return;
    tile_u = id[3:0];
    tile_v = 4'd15 - id[7:4];
    for (int f = 0; f < 6; f++) begin
      if (!open_mask[f]) continue;
      for (int k = 0; k < 6; k++) begin
        c = FACE_CORNERS[f][k];
        vtx.pos_x = {1'b0, x} + c[4];
        vtx.pos_y = {1'b0, y} + c[3];
        vtx.pos_z = {1'b0, z} + c[2];
        vtx.tex_u = {1'b0, tile_u} + c[1];
        vtx.tex_v = {1'b0, tile_v} + c[0];
        vtx.light = FACE_BRIGHTNESS[f];
        vtx.face  = face_t'(3'(f));
        vtx.last  = 1'b0;
        pending_vertices.insert(pending_vertices.size(), vtx);
      end
    end
    if (pending_vertices.size() > first)
      pending_vertices[pending_vertices.size() - 1].last = 1'b1;
  endfunction

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // Leaves valid high on return, so back-to-back voxels need no extra edge.
  task automatic send_voxel(input logic [3:0] x, input logic [3:0] y, input logic [3:0] z,
                            input logic [7:0] id, input logic [5:0] open_mask);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      voxel.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    voxel.vox_x      <= x;
    voxel.vox_y      <= y;
    voxel.vox_z      <= z;
    voxel.block_id   <= id;
    voxel.open_up    <= open_mask[FACE_UP];
    voxel.open_down  <= open_mask[FACE_DOWN];
    voxel.open_east  <= open_mask[FACE_EAST];
    voxel.open_west  <= open_mask[FACE_WEST];
    voxel.open_south <= open_mask[FACE_SOUTH];
    voxel.open_north <= open_mask[FACE_NORTH];
    voxel.valid      <= 1'b1;
    do @(posedge clk); while (!voxel.ready);
    predict_voxel_mesh(x, y, z, id, open_mask);
  endtask

  task automatic wait_mesh_drained();
    @(negedge clk);
    voxel.valid <= 1'b0;
    while (pending_vertices.size() > 0) @(negedge clk);
  endtask

  task automatic test_empty_and_enclosed();
    send_voxel(4'd3, 4'd4, 4'd5, 8'd0, 6'b111111);
    send_voxel(4'd3, 4'd4, 4'd5, 8'd42, 6'b000000);
    send_voxel(4'd0, 4'd0, 4'd0, 8'd0, 6'b000000);
  endtask

  task automatic test_single_faces();
    for (int f = 0; f < 6; f++)
      send_voxel(4'(f + 2), 4'(9 - f), 4'(f * 2), 8'(17 * (f + 1)), 6'(1 << f));
  endtask

  task automatic test_field_extremes();
    send_voxel(4'd0,  4'd0,  4'd0,  8'd1,   6'b111111);
    send_voxel(4'd15, 4'd15, 4'd15, 8'd255, 6'b111111);
    send_voxel(4'd0,  4'd15, 4'd0,  8'd16,  6'b111111);
    send_voxel(4'd15, 4'd0,  4'd15, 8'd15,  6'b111111);
    send_voxel(4'd7,  4'd8,  4'd9,  8'd240, 6'b111111);
    send_voxel(4'd15, 4'd15, 4'd15, 8'd128, 6'b101010);
    send_voxel(4'd0,  4'd0,  4'd0,  8'd127, 6'b010101);
  endtask

  task automatic test_random_voxels();
    logic [7:0] id;
    logic [5:0] open_mask;
    for (int n = 0; n < RANDOM_VOXELS; n++) begin
      if (n % 24 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_VOXELS / 2) wait_mesh_drained();
      id = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      case ($urandom_range(0, 9))
        0:       open_mask = 6'b000000;
        1:       open_mask = 6'b111111;
        default: open_mask = 6'($urandom_range(1, 63));
      endcase
      send_voxel(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(0, 15)), id, open_mask);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // vertex sink: random stall per item, checks every accepted vertex
  initial begin
    int           stall;
    mesh_vertex_t want;
    vertex.ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        vertex.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      vertex.ready <= 1'b1;
      do @(posedge clk); while (!vertex.valid);
      if (pending_vertices.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected vertex, expected none, got pos %0d,%0d,%0d face %0d",
                 $time, vertex.pos_x, vertex.pos_y, vertex.pos_z, vertex.face_dir);
      end else begin
        want = pending_vertices.pop_front();
        compare_field("pos_x",       want.pos_x,      vertex.pos_x);
        compare_field("pos_y",       want.pos_y,      vertex.pos_y);
        compare_field("pos_z",       want.pos_z,      vertex.pos_z);
        compare_field("tex_u",       want.tex_u,      vertex.tex_u);
        compare_field("tex_v",       want.tex_v,      vertex.tex_v);
        compare_field("light_level", want.light,      vertex.light_level);
        compare_field("face_dir",    int'(want.face), vertex.face_dir);
        compare_field("last_vertex", want.last,       vertex.last_vertex);
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((voxel.valid && voxel.ready) || (vertex.valid && vertex.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mismatches       = 0;
    idle_cycles      = 0;
    tx_steady        = 1'b0;
    rx_steady        = 1'b0;
    rst              = 1'b1;
    voxel.valid      = 1'b0;
    voxel.vox_x      = '0;
    voxel.vox_y      = '0;
    voxel.vox_z      = '0;
    voxel.block_id   = '0;
    voxel.open_up    = 1'b0;
    voxel.open_down  = 1'b0;
    voxel.open_east  = 1'b0;
    voxel.open_west  = 1'b0;
    voxel.open_south = 1'b0;
    voxel.open_north = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_enclosed();
    test_single_faces();
    test_field_extremes();
    wait_mesh_drained();
    test_random_voxels();

    wait_mesh_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
src/vfcm_pkg.sv
src/vfcm_if.sv
src/vfcm_queue.sv
src/vfcm_front.sv
src/vfcm_back.sv
src/voxel_face_culling_mesher.sv
tb/tb_voxel_face_culling_mesher.sv
